// ===== rtl/double_ended_queue_macros.svh =====
// Assertion macros for the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define DQ_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DQ_ASSERT(name, clk, rst, prop, msg)
`define DQ_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== rtl/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg
// Types, codes and default sizes shared by the double-ended queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W     = 2;
  localparam int WORD_W     = 32;
  localparam int OUT_CNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } dq_func_t;

  typedef struct packed {
    dq_func_t            func;
    logic [WORD_W-1:0]   data_in;
  } dq_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]    data_out;
    logic                 op_error;
    logic                 is_empty_flag;
    logic [OUT_CNT_W-1:0] fill_count;
  } dq_out_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;     // apply the request being transferred in
    logic capture;  // load the read word into the result
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_need;  // request is a pop that will read the store
  } dq_status_t;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Push or rejected request: result valid in the cycle after the request transfer.
// Successful pop: result passes the read state, then send (registered store read).
// A new request is taken in the cycle its predecessor's result transfers out, so
// pushes sustain one per cycle without output stall; none is taken during a read.
// Synchronous active-high reset empties the queue (head and count to zero);
// store contents are not cleared and are never read before being written.
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue over a ring store with head pointer and count.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dq_pkg::dq_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dq_pkg::dq_out_t      out_data
);

  import dq_pkg::*;

  dq_cmd_t    cmd;
  dq_status_t status;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/dq_ram.sv =====
// ---------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dq_datapath.sv =====
// ---------------------------------------------------------------------------
// dq_datapath
// Ring pointers, fill count, word store and result register of the queue.
// ---------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_macros.svh"

module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dq_pkg::dq_in_t     in_data,
  input  wire dq_pkg::dq_cmd_t    cmd,
  output dq_pkg::dq_status_t      status,
  output dq_pkg::dq_out_t         out_data
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 2;

  localparam logic [CW-1:0] FULL      = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         count_inc;
  logic [CW-1:0]         count_dec;
  logic [CW-1:0]         offs;
  logic [SW-1:0]         pos_sum;
  logic [AW-1:0]         pos;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         head_inc;
  logic                  is_push;
  logic                  is_front;
  logic                  full;
  logic                  empty;
  logic                  push_ok;
  logic                  pop_ok;
  logic                  op_err;

  logic                  res_err;
  logic                  res_empty;
  logic [CW-1:0]         res_cnt;
  logic [WORD_W-1:0]     res_data;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign is_push  = (in_data.func == FUNC_PUSH_FRONT) || (in_data.func == FUNC_PUSH_BACK);
  assign is_front = (in_data.func == FUNC_PUSH_FRONT) || (in_data.func == FUNC_POP_FRONT);
  assign full     = (count == FULL);
  assign empty    = (count == '0);
  assign push_ok  = is_push && !full;
  assign pop_ok   = !is_push && !empty;
  assign op_err   = is_push ? full : empty;

  assign head_dec = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign head_inc = (head == LAST_SLOT) ? '0 : head + 1'b1;

  assign count_inc = count + 1'b1;
  assign count_dec = count - 1'b1;

  // Back slot: head + count for a push, head + count - 1 for a pop, wrapped once
  assign offs    = is_push ? count : count_dec;
  assign pos_sum = SW'(head) + SW'(offs);
  assign pos     = (pos_sum >= DEPTH_S) ? AW'(pos_sum - DEPTH_S) : AW'(pos_sum);

  always_comb begin
    if (push_ok) begin
      count_next = count_inc;
    end else if (pop_ok) begin
      count_next = count_dec;
    end else begin
      count_next = count;
    end
  end

  assign ram_we    = cmd.exec && push_ok;
  assign ram_waddr = is_front ? head_dec : pos;
  assign ram_wdata = DATA_WIDTH'(in_data.data_in);
  assign ram_re    = cmd.exec && pop_ok;
  assign ram_raddr = is_front ? head : pos;

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
      if (is_front && push_ok) begin
        head <= head_dec;
      end else if (is_front && pop_ok) begin
        head <= head_inc;
      end
    end
  end

  // Result fields; the popped word is loaded from the store read in the read state
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_err   <= op_err;
      res_cnt   <= count_next;
      res_empty <= (count_next == '0);
      res_data  <= '0;
    end else if (cmd.capture) begin
      res_data  <= WORD_W'(ram_rdata);
    end
  end

  assign status.rd_need = pop_ok;

  assign out_data.data_out      = res_data;
  assign out_data.op_error      = res_err;
  assign out_data.is_empty_flag = res_empty;
  assign out_data.fill_count    = OUT_CNT_W'(res_cnt);

  `DQ_ASSERT(a_count_range, clk, rst, count <= FULL, "fill count above depth")
  `DQ_ASSERT(a_err_holds, clk, rst, (cmd.exec && op_err) |=> ($stable(head) && $stable(count)), "rejected request changed queue state")
  `DQ_ASSERT(a_push_grows, clk, rst, (cmd.exec && push_ok) |=> (count == $past(count_inc)), "push did not grow the count")

endmodule

`default_nettype wire

// ===== rtl/dq_ctrl.sv =====
// ---------------------------------------------------------------------------
// dq_ctrl
// Handshake controller: sequences accept, store read and result transfer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_macros.svh"

module dq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire dq_pkg::dq_status_t status,
  output dq_pkg::dq_cmd_t         cmd
);

  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  state_t state;
  logic   accept;

  // Take a new request when idle, or when the waiting result leaves this cycle
  assign in_stall = !((state == S_IDLE) || ((state == S_SEND) && !out_stall));
  assign accept   = in_valid && !in_stall;

  assign cmd.exec    = accept;
  assign cmd.capture = (state == S_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE, S_SEND: begin
          if (accept) begin
            state     <= status.rd_need ? S_READ : S_SEND;
            out_valid <= !status.rd_need;
          end else if (state == S_SEND && !out_stall) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          state     <= S_SEND;
          out_valid <= 1'b1;
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  `DQ_ASSERT(a_read_after_pop, clk, rst, (state == S_READ) |-> $past(accept && status.rd_need), "read state without an accepted pop")
  `DQ_ASSERT(a_no_accept_in_read, clk, rst, (state == S_READ) |-> in_stall, "request taken while a read is pending")
  `DQ_ASSERT(a_valid_matches_state, clk, rst, out_valid == (state == S_SEND), "result valid out of step with state")

endmodule

`default_nettype wire

// ===== dv/double_ended_queue_checker.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue_checker
// Watches both channels of the double-ended queue, predicts each result from
// a shadow ring of words, and compares every result field by field in order.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_checker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_stall,
  input  wire dq_pkg::dq_in_t  in_data,
  input  wire logic            out_valid,
  input  wire logic            out_stall,
  input  wire dq_pkg::dq_out_t out_data,
  output int                   outstanding,
  output int                   fail_count
);

  import dq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  logic [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned       front_pos;
  int unsigned       word_count;
  dq_out_t           pending_results[$];

  // Advance the shadow queue by one request and return the result it causes.
  function automatic dq_out_t apply_request(input dq_in_t req);
    dq_out_t res;
    res = '0;
    case (req.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (word_count >= DEPTH) begin
          res.op_error = 1'b1;
        end else if (req.func == FUNC_PUSH_FRONT) begin
          front_pos = (front_pos + DEPTH - 1) % DEPTH;
          shadow_words[front_pos] = req.data_in;
          word_count++;
        end else begin
          shadow_words[(front_pos + word_count) % DEPTH] = req.data_in;
          word_count++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (word_count == 0) begin
          res.op_error = 1'b1;
        end else if (req.func == FUNC_POP_FRONT) begin
          res.data_out = shadow_words[front_pos];
          front_pos = (front_pos + 1) % DEPTH;
          word_count--;
        end else begin
          res.data_out = shadow_words[(front_pos + word_count - 1) % DEPTH];
          word_count--;
        end
      end
      default: ;
    endcase
    res.is_empty_flag = (word_count == 0);
    res.fill_count    = OUT_CNT_W'(word_count);
    return res;
  endfunction

  function automatic void compare_result(input dq_out_t want, input dq_out_t got);
    bit bad;
    bad = 1'b0;
    if (got.data_out !== want.data_out) begin
      $display("%0t: data_out expected %h got %h", $time, want.data_out, got.data_out);
      bad = 1'b1;
    end
    if (got.op_error !== want.op_error) begin
      $display("%0t: op_error expected %b got %b", $time, want.op_error, got.op_error);
      bad = 1'b1;
    end
    if (got.is_empty_flag !== want.is_empty_flag) begin
      $display("%0t: is_empty_flag expected %b got %b", $time, want.is_empty_flag,
               got.is_empty_flag);
      bad = 1'b1;
    end
    if (got.fill_count !== want.fill_count) begin
      $display("%0t: fill_count expected %0d got %0d", $time, want.fill_count,
               got.fill_count);
      bad = 1'b1;
    end
    if (bad) fail_count++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      front_pos  = 0;
      word_count = 0;
      fail_count = 0;
      pending_results.delete();
    end else begin
      // Check the outgoing transfer first: a result never leaves in the
      // cycle its request comes in.
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, expected none got %h", $time, out_data);
          fail_count++;
        end else begin
          compare_result(pending_results[0], out_data);
          pending_results.delete(0);
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.insert(pending_results.size(), apply_request(in_data));
      end
    end
    outstanding = pending_results.size();
  end

endmodule

`default_nettype wire

// ===== dv/double_ended_queue_tb.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue_tb
// Drives push and pop requests into the double-ended queue: a directed pass
// over empty, full and wrap cases, then random runs biased toward filling or
// draining, under three idling mixes on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int REQS_PER_PHASE = 560;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  dq_in_t  in_data;
  logic    out_valid;
  logic    out_stall;
  dq_out_t out_data;
  int      outstanding;
  int      fail_count;
  int      send_gap_pct;
  int      recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  double_ended_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  double_ended_queue_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one request and hold it until the transfer.
  task automatic send_op(input dq_func_t func, input logic [WORD_W-1:0] word);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data.func <= func;
    in_data.data_in <= word;
    do @(posedge clk); while (in_stall);
  endtask

  // Random requests in runs that lean toward pushing, popping or neither,
  // so the queue swings between empty and full.
  task automatic send_random(input int n);
    int i;
    int push_pct;
    int run_left;
    bit push;
    bit front;
    run_left = 0;
    push_pct = 50;
    for (i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      run_left--;
      push  = ($urandom_range(0, 99) < push_pct);
      front = $urandom_range(0, 1);
      if (push) send_op(front ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, random_word());
      else      send_op(front ? FUNC_POP_FRONT : FUNC_POP_BACK, random_word());
    end
  endtask

  initial begin
    int phase;
    int k;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 11;
          recv_stall_pct = 59;
        end
        1: begin
          send_gap_pct   = 59;
          recv_stall_pct = 11;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 0) begin
        // Pops on an empty queue, extreme words, then fill past full.
        send_op(FUNC_POP_FRONT, 32'hA5A5_5A5A);
        send_op(FUNC_POP_BACK, '1);
        send_op(FUNC_PUSH_FRONT, '1);
        send_op(FUNC_PUSH_BACK, '0);
        send_op(FUNC_POP_BACK, '1);
        send_op(FUNC_POP_FRONT, '0);
        for (k = 0; k < DEPTH_DEF; k++) begin
          send_op(k[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, $urandom());
        end
        send_op(FUNC_PUSH_FRONT, 32'h1234_5678);
        send_op(FUNC_PUSH_BACK, 32'h8765_4321);
      end
      send_random(REQS_PER_PHASE);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[double_ended_queue] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_datapath.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue.sv
dv/double_ended_queue_checker.sv
dv/double_ended_queue_tb.sv
